>>> hw/rtl/skh_pkg.sv
// ----------------------------------------------------------------------------
// skh_pkg
// Shared widths, types and mixing functions for the section key hash.
// ----------------------------------------------------------------------------
package skh_pkg;

	localparam int SEED_W    = 32;
	localparam int SECTION_W = 30;
	localparam int BYTE_W    = 8;
	localparam int HASH_W    = 32;

	// Stream payload layout.
	localparam int S_TDATA_W = 72;
	localparam int S_TUSER_W = 2;
	localparam int M_TDATA_W = 32;

	localparam int SEED_LSB    = 0;
	localparam int SECTION_LSB = SEED_LSB + SEED_W;
	localparam int BYTE_LSB    = SECTION_LSB + SECTION_W;

	localparam int TUSER_FIRST    = 0;
	localparam int TUSER_HAS_BYTE = 1;

	typedef logic [HASH_W-1:0] hash_t;

	// Control handed to the absorb stage for one beat.
	typedef struct packed {
		logic load;
		logic first;
		logic has_byte;
	} absorb_ctl_t;

	// First half of the premix: complement shift-add and an xor-shift.
	function automatic hash_t premix_lo(input hash_t x);
		hash_t p;
		p = (x << 15) + ~x;
		return p ^ (p >> 12);
	endfunction

	// Second half: times five, xor-shift, times 2057 as shift-adds, xor-shift.
	function automatic hash_t premix_hi(input hash_t p);
		hash_t t;
		t = p + (p << 2);
		t = t ^ (t >> 4);
		t = t + (t << 3) + (t << 11);
		return t ^ (t >> 16);
	endfunction

	// One-at-a-time step with the byte taken as a signed char.
	function automatic hash_t absorb_step(input hash_t s, input logic [BYTE_W-1:0] b);
		hash_t v;
		v = s + {{(HASH_W-BYTE_W){b[BYTE_W-1]}}, b};
		v = v + (v << 10);
		return v ^ (v >> 6);
	endfunction

	function automatic hash_t finish_mix(input hash_t s);
		hash_t v;
		v = s + (s << 3);
		v = v ^ (v >> 11);
		return v + (v << 15);
	endfunction

endpackage

>>> hw/rtl/skh_absorb.sv
// ----------------------------------------------------------------------------
// skh_absorb
// Running hash register and the per-byte absorb step.
// ----------------------------------------------------------------------------
module skh_absorb (
	input  logic                clk,
	input  logic                arst_n,
	input  skh_pkg::absorb_ctl_t ctl,
	input  skh_pkg::hash_t      premix,
	input  logic [skh_pkg::BYTE_W-1:0] key_byte,
	output skh_pkg::hash_t      mixed
);
	import skh_pkg::*;

	hash_t running_hash_q;
	hash_t base;

	always_comb begin
		base  = ctl.first ? premix : running_hash_q;
		mixed = ctl.has_byte ? absorb_step(base, key_byte) : base;
	end

	// The final avalanche is applied downstream and never written back here.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_hash_q <= '0;
		end else if (ctl.load) begin
			running_hash_q <= mixed;
		end
	end

endmodule

>>> hw/rtl/section_key_string_hash.sv
// ----------------------------------------------------------------------------
// section_key_string_hash
// Streaming 32-bit key hash with a seeded, premixed start and a final avalanche.
// ----------------------------------------------------------------------------
// A key arrives as a run of beats on the s_ channel, one key byte per beat.
// The beat with tuser.first set adds seed and section and premixes the sum;
// beats with tuser.has_byte set absorb key_byte; the beat with tlast set
// produces one hash beat on the m_ channel. An empty key is a single beat
// with first and tlast set and has_byte clear.
// Throughput is one beat per cycle while m_tready holds no result back. The
// path is five register stages: input, two premix stages, the absorb stage
// holding the running hash, and the finishing output register, through which
// a hash reaches m_tdata after its tlast beat is taken. Only the absorb stage
// carries state from beat to beat, and its step is computed combinationally.
// Each stage moves forward whenever the stage after it is empty or moving,
// so bubbles are squeezed out; when m_tready stays low, the pipeline fills
// and s_tready drops once all five stages hold a beat.
// Reset clears all stage valids and sets the running hash to zero.
// ----------------------------------------------------------------------------
module section_key_string_hash (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// seed [31:0], section [61:32], key_byte [69:62], zero [71:70]
	input  logic [skh_pkg::S_TDATA_W-1:0] s_tdata,
	// first [0], has_byte [1]
	input  logic [skh_pkg::S_TUSER_W-1:0] s_tuser,
	input  logic                         s_tlast,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// hash [31:0]
	output logic [skh_pkg::M_TDATA_W-1:0] m_tdata
);
	import skh_pkg::*;

	// Stage valids.
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;

	// Stage payloads.
	hash_t                  seed_sum_s1;
	logic                   first_s1, has_byte_s1, last_s1;
	logic [BYTE_W-1:0]      byte_s1;
	hash_t                  pm_s2;
	logic                   first_s2, has_byte_s2, last_s2;
	logic [BYTE_W-1:0]      byte_s2;
	hash_t                  pm_s3;
	logic                   first_s3, has_byte_s3, last_s3;
	logic [BYTE_W-1:0]      byte_s3;
	hash_t                  mixed_s4;
	hash_t                  hash_s5;

	absorb_ctl_t            ctl;
	hash_t                  mixed;

	assign rdy5     = !v_s5 || m_tready;
	assign rdy4     = !v_s4 || rdy5;
	assign rdy3     = !v_s3 || rdy4;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign s_tready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy1) begin
				v_s1 <= s_tvalid;
			end
			if (rdy2) begin
				v_s2 <= v_s1;
			end
			if (rdy3) begin
				v_s3 <= v_s2;
			end
			// Only beats that end a key continue past the absorb stage.
			if (rdy4) begin
				v_s4 <= v_s3 && last_s3;
			end
			if (rdy5) begin
				v_s5 <= v_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			seed_sum_s1 <= s_tdata[SEED_LSB +: SEED_W]
				+ HASH_W'(s_tdata[SECTION_LSB +: SECTION_W]);
			byte_s1     <= s_tdata[BYTE_LSB +: BYTE_W];
			first_s1    <= s_tuser[TUSER_FIRST];
			has_byte_s1 <= s_tuser[TUSER_HAS_BYTE];
			last_s1     <= s_tlast;
		end
		if (rdy2) begin
			pm_s2       <= premix_lo(seed_sum_s1);
			byte_s2     <= byte_s1;
			first_s2    <= first_s1;
			has_byte_s2 <= has_byte_s1;
			last_s2     <= last_s1;
		end
		if (rdy3) begin
			pm_s3       <= premix_hi(pm_s2);
			byte_s3     <= byte_s2;
			first_s3    <= first_s2;
			has_byte_s3 <= has_byte_s2;
			last_s3     <= last_s2;
		end
		if (rdy4) begin
			mixed_s4 <= mixed;
		end
		if (rdy5) begin
			hash_s5 <= finish_mix(mixed_s4);
		end
	end

	assign ctl.load     = v_s3 && rdy4;
	assign ctl.first    = first_s3;
	assign ctl.has_byte = has_byte_s3;

	skh_absorb u_absorb (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.premix   (pm_s3),
		.key_byte (byte_s3),
		.mixed    (mixed)
	);

	assign m_tvalid = v_s5;
	assign m_tdata  = hash_s5;

endmodule

>>> hw/rtl/skh_checker.sv
// ----------------------------------------------------------------------------
// skh_checker
// Port-level checks for the section key hash, bound to the top level.
// ----------------------------------------------------------------------------
module skh_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         s_tvalid,
	input logic                         s_tready,
	input logic                         s_tlast,
	input logic                         m_tvalid,
	input logic                         m_tready,
	input logic [skh_pkg::M_TDATA_W-1:0] m_tdata
);
	import skh_pkg::*;

	// A result beat waiting for the receiver stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result beat withdrawn while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result data changed while stalled");

	// The input side only backs up once the output is full and stalled.
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without a stalled result");

	// Nothing comes out right after reset.
	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !m_tvalid)
		else $error("result beat present right after reset");

	// Right after reset, no result appears unless a tlast beat has been taken.
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) ##1 !(s_tvalid && s_tready && s_tlast) |=> !m_tvalid)
		else $error("result beat without a finished key");

endmodule

bind section_key_string_hash skh_checker u_skh_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tlast  (s_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
